FILE: design/gtmt_pkg.sv
// shared types, constants and the crc step function for the memo table
package gtmt_pkg;

    localparam int INDEX_BITS_DEF = 12;
    localparam int KEY_W          = 64;
    localparam int LEVEL_W        = 5;
    localparam int GEN_W          = 32;
    localparam int HASH_STEPS     = KEY_W / 8;
    localparam int HASH_CNT_W     = $clog2(HASH_STEPS);

    localparam logic [31:0] CRC_POLY = 32'h82F63B78;

    // operation codes
    localparam logic OP_CHECK   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef struct packed {
        logic               op;
        logic [KEY_W-1:0]   key;
        logic [LEVEL_W-1:0] level;
    } in_word_t;

    typedef struct packed {
        logic hit;
        logic cleared;
    } out_word_t;

    // one table slot as stored in memory
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [LEVEL_W-1:0] level;
        logic [GEN_W-1:0]   gen;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CMP,
        ST_ADV,
        ST_WRAP_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic hash_step;
        logic rd_en;
        logic ld_check;
        logic gen_inc;
        logic gen_wrap;
        logic clr_write;
        logic ld_adv;
        logic ld_wrap;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hash_last;
        logic clr_last;
        logic gen_max;
        logic out_free;
    } sts_t;

    // reflected crc32c over one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: design/gtmt_ram.sv
// generic simple dual port ram with registered read
module gtmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/gtmt_ctrl.sv
// controller state machine for the memo table
module gtmt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_op,
    output logic          s_ready,
    output gtmt_pkg::cmd_t cmd,
    input  gtmt_pkg::sts_t sts
);
    import gtmt_pkg::*;

    state_t state_reg, state_next;
    logic   wrap_pend_reg, wrap_pend_next;

    // state register, table sweep runs first after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            wrap_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wrap_pend_reg <= wrap_pend_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        wrap_pend_next = wrap_pend_reg;
        cmd            = '0;
        s_ready        = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_write = 1'b1;
                if (sts.clr_last) begin
                    state_next = wrap_pend_reg ? ST_WRAP_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = (s_op == OP_ADVANCE) ? ST_ADV : ST_HASH;
                end
            end
            ST_HASH: begin
                cmd.hash_step = 1'b1;
                if (sts.hash_last) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (sts.out_free) begin
                    cmd.ld_check = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_ADV: begin
                if (sts.gen_max) begin
                    cmd.gen_wrap   = 1'b1;
                    wrap_pend_next = 1'b1;
                    state_next     = ST_CLEAR;
                end else if (sts.out_free) begin
                    cmd.gen_inc = 1'b1;
                    cmd.ld_adv  = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_WRAP_DONE: begin
                if (sts.out_free) begin
                    cmd.ld_wrap    = 1'b1;
                    wrap_pend_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/gtmt_dp.sv
// datapath: crc hash, generation, clear pointer, slot memory and result word
module gtmt_dp #(
    parameter int INDEX_BITS = gtmt_pkg::INDEX_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  gtmt_pkg::cmd_t      cmd,
    output gtmt_pkg::sts_t      sts,
    input  gtmt_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gtmt_pkg::out_word_t m_data
);
    import gtmt_pkg::*;

    localparam int DEPTH = 2 ** INDEX_BITS;

    logic [KEY_W-1:0]      key_reg;
    logic [LEVEL_W-1:0]    level_reg;
    logic [31:0]           crc_reg;
    logic [HASH_CNT_W-1:0] cnt_reg;
    logic [INDEX_BITS-1:0] clr_ptr_reg;
    logic [GEN_W-1:0]      gen_reg;
    logic                  out_valid_reg;
    out_word_t             out_reg;

    logic [INDEX_BITS-1:0] idx;
    logic [7:0]            hash_byte;
    slot_t                 rd_slot;
    slot_t                 wr_slot;
    logic [SLOT_W-1:0]     rdata;
    logic                  hit;
    logic                  we;
    logic [INDEX_BITS-1:0] waddr;

    assign idx       = crc_reg[INDEX_BITS-1:0];
    assign hash_byte = key_reg[{cnt_reg, 3'b000} +: 8];
    assign rd_slot   = slot_t'(rdata);

    // captured word
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            key_reg   <= s_data.key;
            level_reg <= s_data.level;
        end
    end

    // one byte of crc per cycle, low byte first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.start) begin
            crc_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.hash_step) begin
            crc_reg <= crc_byte(crc_reg, hash_byte);
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // current generation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg <= GEN_W'(1);
        end else if (cmd.gen_wrap) begin
            gen_reg <= GEN_W'(1);
        end else if (cmd.gen_inc) begin
            gen_reg <= gen_reg + 1'b1;
        end
    end

    // sweep pointer, wraps back to zero after the last slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_ptr_reg <= '0;
        end else if (cmd.clr_write) begin
            clr_ptr_reg <= clr_ptr_reg + 1'b1;
        end
    end

    // slot compare
    assign hit = (rd_slot.key == key_reg) && (rd_slot.level <= level_reg) &&
                 (rd_slot.gen == gen_reg);

    // slot write: sweep or replace on miss
    assign wr_slot.key   = key_reg;
    assign wr_slot.level = level_reg;
    assign wr_slot.gen   = gen_reg;
    assign we    = cmd.clr_write || (cmd.ld_check && !hit);
    assign waddr = cmd.clr_write ? clr_ptr_reg : idx;

    gtmt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (cmd.clr_write ? {SLOT_W{1'b0}} : SLOT_W'(wr_slot)),
        .rd_en (cmd.rd_en),
        .raddr (idx),
        .rdata (rdata)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.ld_check || cmd.ld_adv || cmd.ld_wrap) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_check) begin
            out_reg.hit     <= hit;
            out_reg.cleared <= 1'b0;
        end else if (cmd.ld_adv) begin
            out_reg.hit     <= 1'b0;
            out_reg.cleared <= 1'b0;
        end else if (cmd.ld_wrap) begin
            out_reg.hit     <= 1'b0;
            out_reg.cleared <= 1'b1;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // status back to the controller
    assign sts.hash_last = (cnt_reg == HASH_CNT_W'(HASH_STEPS - 1));
    assign sts.clr_last  = (clr_ptr_reg == {INDEX_BITS{1'b1}});
    assign sts.gen_max   = (gen_reg == {GEN_W{1'b1}});
    assign sts.out_free  = !out_valid_reg || m_ready;

endmodule

FILE: design/generation_tagged_memo_table.sv
// top level of the generation tagged direct mapped memo table
//
//   port group   dir   word        meaning
//   s_*          in    in_word_t   check (op 0) or advance generation (op 1)
//   m_*          out   out_word_t  hit / cleared, one word per input word
//
// A check passes from acceptance through one crc byte step per key byte, one slot
// memory read and one compare and write before s_ready is raised again.
// An advance steps the generation and posts its result word; a generation wrap
// instead sweeps the slot memory, then posts the result word from its own state.
// After reset the same sweep zeroes the table, s_ready low.
// A stalled m_ready holds the result; the next word waits in its last state.
module generation_tagged_memo_table #(
    parameter int INDEX_BITS = gtmt_pkg::INDEX_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gtmt_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gtmt_pkg::out_word_t m_data
);
    import gtmt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // controller
    gtmt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_data.op),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // datapath
    gtmt_dp #(
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: design/gtmt_checker.sv
// port level checks for the memo table and their bind
module gtmt_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input gtmt_pkg::out_word_t m_data
);
    import gtmt_pkg::*;

    // a stalled result stays
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // a stalled result holds its word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result word changed while stalled");

    // a word never reports both a hit and a clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.hit && m_data.cleared))
        else $error("hit and cleared both set");

    // one word at a time: busy right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready again right after an accept");

endmodule

bind generation_tagged_memo_table gtmt_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: sim/generation_tagged_memo_table_test.sv
// self-checking testbench for the generation tagged memo table: predicted hit / cleared per word
`timescale 1ns / 100ps

module generation_tagged_memo_table_test;

    import gtmt_pkg::*;

    localparam int INDEX_BITS  = INDEX_BITS_DEF;
    localparam int TABLE_SLOTS = 1 << INDEX_BITS;
    localparam int POOL_SIZE   = 48;
    localparam int ROUNDS      = 7;
    localparam int ROUND_WORDS = 250;
    localparam int SETTLE      = 40;

    // predicted table contents and expected result words
    class memo_scoreboard;
        logic [KEY_W-1:0]   slot_key   [TABLE_SLOTS];
        logic [LEVEL_W-1:0] slot_level [TABLE_SLOTS];
        logic [GEN_W-1:0]   slot_gen   [TABLE_SLOTS];
        logic [GEN_W-1:0]   cur_gen;
        out_word_t          result_q[$];
        int                 errors;

        function new();
            wipe();
            cur_gen = 1;
            errors  = 0;
        endfunction

        function void wipe();
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                slot_key[i]   = '0;
                slot_level[i] = '0;
                slot_gen[i]   = '0;
            end
        endfunction

        // crc32c over the low word then the high word, low bits pick the slot
        static function int slot_of(logic [KEY_W-1:0] key);
            logic [31:0] crc;
            crc = 32'd0;
            for (int half = 0; half < 2; half++) begin
                crc = crc ^ key[half*32 +: 32];
                for (int b = 0; b < 32; b++) begin
                    crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
                end
            end
            return int'(crc & (TABLE_SLOTS - 1));
        endfunction

        // accepted input word: update prediction, queue its result
        function void note_word(in_word_t w);
            out_word_t res;
            int        idx;
            res = '0;
            if (w.op == OP_CHECK) begin
                idx = slot_of(w.key);
                if (slot_key[idx] == w.key && slot_level[idx] <= w.level &&
                    slot_gen[idx] == cur_gen) begin
                    res.hit = 1'b1;
                end else begin
                    slot_key[idx]   = w.key;
                    slot_level[idx] = w.level;
                    slot_gen[idx]   = cur_gen;
                end
            end else begin
                cur_gen = cur_gen + 1;
                // wrap to zero clears everything and restarts at one
                if (cur_gen == '0) begin
                    wipe();
                    cur_gen     = 1;
                    res.cleared = 1'b1;
                end
            end
            result_q.push_back(res);
        endfunction

        // accepted result word against the oldest expectation
        function void check_word(out_word_t got);
            out_word_t want;
            if (result_q.size() == 0) begin
                $error("result word with nothing expected: hit=%0b cleared=%0b",
                       got.hit, got.cleared);
                errors++;
                return;
            end
            want = result_q.pop_front();
            if (got.hit !== want.hit) begin
                $error("hit: expected %0b, actual %0b", want.hit, got.hit);
                errors++;
            end
            if (got.cleared !== want.cleared) begin
                $error("cleared: expected %0b, actual %0b", want.cleared, got.cleared);
                errors++;
            end
        endfunction

        function int outstanding();
            return result_q.size();
        endfunction
    endclass

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    memo_scoreboard   memo_model;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    bit               calm;
    int               hold_cycles;
    int               wait_cnt;

    generation_tagged_memo_table #(
        .INDEX_BITS(INDEX_BITS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 10 ns clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic in_word_t make_word(logic op, logic [KEY_W-1:0] key,
                                           logic [LEVEL_W-1:0] level);
        in_word_t w;
        w.op    = op;
        w.key   = key;
        w.level = level;
        return w;
    endfunction

    // two distinct keys that land in the same slot
    task automatic find_colliding_keys(output logic [KEY_W-1:0] ka,
                                       output logic [KEY_W-1:0] kb);
        logic [KEY_W-1:0] seen_key [TABLE_SLOTS];
        bit               seen_ok  [TABLE_SLOTS];
        logic [KEY_W-1:0] k;
        int               idx;
        bit               found;
        for (int i = 0; i < TABLE_SLOTS; i++) seen_ok[i] = 1'b0;
        found = 1'b0;
        ka    = '0;
        kb    = '0;
        while (!found) begin
            k   = {$urandom(), $urandom()};
            idx = memo_scoreboard::slot_of(k);
            if (seen_ok[idx] && seen_key[idx] != k) begin
                ka    = seen_key[idx];
                kb    = k;
                found = 1'b1;
            end else begin
                seen_ok[idx]  = 1'b1;
                seen_key[idx] = k;
            end
        end
    endtask

    // offer one word, hold it until accepted, then maybe leave a gap
    task automatic send_word(in_word_t w);
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        memo_model.note_word(w);
        if (!calm && $urandom_range(99) < 15) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    // stop offering until every expected result is back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (memo_model.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic fill_pool();
        logic [KEY_W-1:0] ka;
        logic [KEY_W-1:0] kb;
        find_colliding_keys(ka, kb);
        key_pool[0] = ka;
        key_pool[1] = kb;
        key_pool[2] = '0;
        key_pool[3] = '1;
        for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = {$urandom(), $urandom()};
    endtask

    // mostly checks on a small key pool so hits and evictions are common
    task automatic send_random_word();
        int               r;
        logic [KEY_W-1:0] k;
        r = $urandom_range(99);
        k = {$urandom(), $urandom()};
        if (r < 5) begin
            send_word(make_word(OP_ADVANCE, k, LEVEL_W'($urandom_range(31))));
        end else if (r < 12) begin
            send_word(make_word(OP_CHECK, k, LEVEL_W'($urandom_range(31))));
        end else begin
            send_word(make_word(OP_CHECK, key_pool[$urandom_range(POOL_SIZE - 1)],
                                LEVEL_W'($urandom_range(31))));
        end
    endtask

    // result side: random back-pressure, long hold-off on request
    task automatic drain_outputs();
        forever begin
            if (hold_cycles > 0) begin
                m_ready     <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                m_ready <= (calm || $urandom_range(99) >= 15);
            end
            @(posedge aclk);
            if (m_valid && m_ready) memo_model.check_word(m_data);
        end
    endtask

    initial begin
        logic [KEY_W-1:0] ka;
        logic [KEY_W-1:0] kb;
        logic [KEY_W-1:0] km;

        memo_model  = new();
        calm        = 1'b0;
        hold_cycles = 0;

        // reset, then the block sweeps its table before taking words
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        fork
            drain_outputs();
        join_none

        // directed: key of zero on a never written slot, then a hit
        send_word(make_word(OP_CHECK, '0, 5'd0));
        send_word(make_word(OP_CHECK, '0, 5'd0));
        // all ones key, deepest level, then a shallower check misses
        send_word(make_word(OP_CHECK, '1, 5'd31));
        send_word(make_word(OP_CHECK, '1, 5'd31));
        send_word(make_word(OP_CHECK, '1, 5'd0));
        send_word(make_word(OP_CHECK, '1, 5'd31));
        // level compare: lower misses and rewrites, equal and deeper hit
        km = {$urandom(), $urandom()};
        send_word(make_word(OP_CHECK, km, 5'd10));
        send_word(make_word(OP_CHECK, km, 5'd9));
        send_word(make_word(OP_CHECK, km, 5'd9));
        send_word(make_word(OP_CHECK, km, 5'd10));
        // two keys fighting over one slot
        find_colliding_keys(ka, kb);
        send_word(make_word(OP_CHECK, ka, 5'd3));
        send_word(make_word(OP_CHECK, kb, 5'd3));
        send_word(make_word(OP_CHECK, ka, 5'd3));
        send_word(make_word(OP_CHECK, ka, 5'd3));
        // advance: older entries stop matching
        send_word(make_word(OP_ADVANCE, '0, 5'd0));
        send_word(make_word(OP_CHECK, '0, 5'd31));
        send_word(make_word(OP_CHECK, '0, 5'd31));
        send_word(make_word(OP_CHECK, ka, 5'd31));
        send_word(make_word(OP_ADVANCE, '1, 5'd31));
        send_word(make_word(OP_CHECK, km, 5'd31));
        send_word(make_word(OP_CHECK, km, 5'd0));
        // a wrap needs 2**32 - 1 advances, far beyond any run, so cleared stays 0
        drain_results();

        for (int round = 0; round < ROUNDS; round++) begin
            fill_pool();
            calm = (round == 2);
            // receiver stalls long while words keep coming
            if (round == 3) hold_cycles = 400;
            for (int n = 0; n < ROUND_WORDS; n++) send_random_word();
            if (round == 4) drain_results();
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        // wait for the tail, bounded
        for (wait_cnt = 0; memo_model.outstanding() != 0 && wait_cnt < 20000; wait_cnt++)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        if (memo_model.errors == 0 && memo_model.outstanding() == 0) begin
            $display("Test completed successfully");
        end else begin
            if (memo_model.outstanding() != 0)
                $error("%0d result words never arrived", memo_model.outstanding());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: generation_tagged_memo_table.f
design/gtmt_pkg.sv
design/gtmt_ram.sv
design/gtmt_ctrl.sv
design/gtmt_dp.sv
design/generation_tagged_memo_table.sv
design/gtmt_checker.sv
sim/generation_tagged_memo_table_test.sv
